FILE: hdl/result_packet_decoder_macros.svh
// ----------------------------------------------------------------------------
// result packet decoder assertion macros
// shared concurrent assertion shorthands, removable with ASSERT_OFF
// ----------------------------------------------------------------------------
`ifndef RESULT_PACKET_DECODER_MACROS_SVH
`define RESULT_PACKET_DECODER_MACROS_SVH

`ifndef ASSERT_OFF

// expression holds at every edge outside reset
`define RPD_ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("rpd assertion failed");

// antecedent implies consequent at the same edge
`define RPD_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rpd assertion failed");

// antecedent implies consequent at the next edge
`define RPD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rpd assertion failed");

`else

`define RPD_ASSERT_ALWAYS(lbl, clk, rst, expr)
`define RPD_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define RPD_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

FILE: hdl/rpd_pkg.sv
// ----------------------------------------------------------------------------
// rpd_pkg
// types, constants and the crc byte update of the result packet decoder
// ----------------------------------------------------------------------------
`default_nettype none

package rpd_pkg;

  localparam int unsigned HDR_LEN  = 48;
  localparam int unsigned PT_LEN   = 36;
  localparam int unsigned HDR_BITS = 8 * HDR_LEN;
  localparam int unsigned PT_BITS  = 8 * PT_LEN;

  localparam logic [31:0] MAGIC_WORD = 32'h3243_4944;
  localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;

  localparam logic [15:0] VERSION_RESET    = 16'd1;
  localparam logic [19:0] MAX_POINTS_RESET = 20'd1000000;

  // configuration register indexes
  localparam logic REG_EXPECTED_VERSION = 1'b0;
  localparam logic REG_MAX_POINTS       = 1'b1;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_POINT  = 2'd1,
    KIND_END    = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_TRUNCATED   = 3'd1,
    ST_UNSUPPORTED = 3'd2,
    ST_LENGTH      = 3'd3,
    ST_COUNT       = 3'd4,
    ST_CRC         = 3'd5,
    ST_FLAGS       = 3'd6
  } status_t;

  typedef struct packed {
    kind_t       kind;
    logic [63:0] word0;
    logic [63:0] word1;
    logic [63:0] word2;
    logic [63:0] word3;
    logic [1:0]  point_flags;
    status_t     status;
    logic        end_mark;
  } item_t;

  // reflected crc-32, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/result_packet_decoder.sv
// result packet decoder: one packet byte accepted per cycle while the 4-entry
// output queue holds two items or fewer; items go out on that queue. a result
// is written into the queue at the edge that accepts its byte. a byte that
// causes two items (point or header plus end) writes both entries together,
// which the queue absorbs. reset: synchronous, clears packet state, queue and
// configuration (version 1, max points 1000000).
// ----------------------------------------------------------------------------
// result_packet_decoder
// header parse, point split and crc-32 check of a byte-serial result packet
// ----------------------------------------------------------------------------
`default_nettype none

module result_packet_decoder
  import rpd_pkg::*;
#(
  parameter int unsigned POSITION_BITS = 32
) (
  input  wire logic         clk,
  input  wire logic         rst,
  // configuration write port
  input  wire logic         cfg_we,
  input  wire logic         cfg_addr,
  input  wire logic [19:0]  cfg_data,
  // byte stream in
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [7:0]   s_tdata,   // [7:0] data_byte
  input  wire logic         s_tlast,   // last
  // item stream out
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [263:0]      m_tdata,   // word0, word1, word2, word3, point_flags, status, pad
  output logic [1:0]        m_tuser,   // kind
  output logic              m_tlast    // end_mark
);

  localparam logic [POSITION_BITS-1:0] POS_HDR     = POSITION_BITS'(HDR_LEN);
  localparam logic [POSITION_BITS-1:0] POS_HDR_END = POSITION_BITS'(HDR_LEN - 1);
  localparam logic [5:0]               IDX_LAST    = 6'(PT_LEN - 1);

  // configuration
  logic [15:0] expected_version;
  logic [19:0] max_points;

  // packet state
  logic [POSITION_BITS-1:0] pos;
  logic [5:0]               pt_idx;
  logic [31:0]              crc;
  logic                     header_ok;
  logic                     flags_bad;
  logic [HDR_BITS-1:0]      hdr;
  logic [PT_BITS-1:0]       pt;

  // output queue
  item_t       q [4];
  logic [1:0]  rd_ptr;
  logic [1:0]  wr_ptr;
  logic [2:0]  count;

  logic                     in_fire;
  logic                     out_fire;
  logic                     pos_lt_hdr;
  logic                     pos_at_hdr_end;
  logic                     pos_max;
  logic                     capture;
  logic [HDR_BITS-1:0]      hdr_view;
  logic [PT_BITS-1:0]       pt_view;
  logic [31:0]              fw;
  logic                     pt_done;
  logic                     hdr_good;
  logic [POSITION_BITS-1:0] pos_next;
  logic [31:0]              crc_next;
  logic                     header_ok_next;
  logic                     flags_bad_next;
  logic [5:0]               pt_idx_next;
  logic [31:0]              f_psize;
  logic [31:0]              f_count;
  logic [31:0]              f_crc;
  logic [37:0]              payload_len;
  logic [37:0]              count_len;
  status_t                  end_status;
  item_t                    item_a;
  item_t                    item_b;
  logic                     a_vld;
  logic                     b_vld;
  logic [2:0]               count_next;

  assign in_fire  = s_tvalid & s_tready;
  assign out_fire = m_tvalid & m_tready;
  assign s_tready = (count <= 3'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_version <= VERSION_RESET;
      max_points       <= MAX_POINTS_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_EXPECTED_VERSION: expected_version <= cfg_data[15:0];
        REG_MAX_POINTS:       max_points       <= cfg_data;
        default: ;
      endcase
    end
  end

  // byte decode
  always_comb begin
    pos_lt_hdr     = (pos < POS_HDR);
    pos_at_hdr_end = (pos == POS_HDR_END);
    pos_max        = &pos;
    capture        = !pos_lt_hdr && !pos_max;

    // current byte enters the top of the point shift line, and of the header shift line while in the header
    hdr_view = pos_lt_hdr ? {s_tdata, hdr[HDR_BITS-1:8]} : hdr;
    pt_view  = {s_tdata, pt[PT_BITS-1:8]};
    fw       = pt_view[287:256];
    pt_done  = capture && (pt_idx == IDX_LAST) && header_ok;

    hdr_good = (hdr_view[31:0] == MAGIC_WORD) &&
               (hdr_view[47:32] == expected_version) &&
               (hdr_view[63:48] == 16'(HDR_LEN)) &&
               (hdr_view[127:96] == 32'(PT_LEN));
    f_psize = hdr_view[95:64];
    f_count = hdr_view[351:320];
    f_crc   = hdr_view[383:352];

    pos_next       = pos_max ? pos : pos + 1'b1;
    crc_next       = pos_lt_hdr ? crc : crc_byte(crc, s_tdata);
    header_ok_next = pos_at_hdr_end ? hdr_good : header_ok;
    flags_bad_next = flags_bad | (pt_done & (|fw[31:2]));
    pt_idx_next    = capture ? ((pt_idx == IDX_LAST) ? 6'd0 : pt_idx + 6'd1) : pt_idx;

    payload_len = 38'(pos_next) - 38'(HDR_LEN);
    count_len   = (38'(f_count) << 5) + (38'(f_count) << 2);

    if (pos_next < POS_HDR) begin
      end_status = ST_TRUNCATED;
    end else if (!header_ok_next) begin
      end_status = ST_UNSUPPORTED;
    end else if (f_psize != 32'(pos_next)) begin
      end_status = ST_LENGTH;
    end else if ((f_count > 32'(max_points)) || (payload_len != count_len)) begin
      end_status = ST_COUNT;
    end else if (~crc_next != f_crc) begin
      end_status = ST_CRC;
    end else if (flags_bad_next) begin
      end_status = ST_FLAGS;
    end else begin
      end_status = ST_OK;
    end

    // header and point never fall on the same byte
    a_vld = pt_done | pos_at_hdr_end;
    item_a = '0;
    if (pt_done) begin
      item_a.kind        = KIND_POINT;
      item_a.word0       = pt_view[63:0];
      item_a.word1       = pt_view[127:64];
      item_a.word2       = pt_view[191:128];
      item_a.word3       = pt_view[255:192];
      item_a.point_flags = fw[1:0];
      item_a.status      = ST_OK;
    end else begin
      item_a.kind        = KIND_HEADER;
      item_a.word0       = hdr_view[191:128];
      item_a.word1       = hdr_view[255:192];
      item_a.word2       = hdr_view[319:256];
      item_a.word3       = {32'd0, f_count};
      item_a.status      = ST_OK;
    end

    b_vld = s_tlast;
    item_b = '0;
    item_b.kind     = KIND_END;
    item_b.status   = end_status;
    item_b.end_mark = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      pt_idx    <= '0;
      crc       <= CRC_INIT;
      header_ok <= 1'b0;
      flags_bad <= 1'b0;
    end else if (in_fire) begin
      if (s_tlast) begin
        pos       <= '0;
        pt_idx    <= '0;
        crc       <= CRC_INIT;
        header_ok <= 1'b0;
        flags_bad <= 1'b0;
      end else begin
        pos       <= pos_next;
        pt_idx    <= pt_idx_next;
        crc       <= crc_next;
        header_ok <= header_ok_next;
        flags_bad <= flags_bad_next;
      end
    end
  end

  // byte shift lines
  always_ff @(posedge clk) begin
    if (in_fire && pos_lt_hdr) begin
      hdr <= hdr_view;
    end
    if (in_fire && capture) begin
      pt <= pt_view;
    end
  end

  // output queue: up to two pushes and one pop a cycle
  always_comb begin
    count_next = count;
    if (in_fire) begin
      count_next = count_next + 3'(a_vld) + 3'(b_vld);
    end
    if (out_fire) begin
      count_next = count_next - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (a_vld) begin
        q[wr_ptr] <= item_a;
        if (b_vld) begin
          q[wr_ptr + 2'd1] <= item_b;
        end
      end else if (b_vld) begin
        q[wr_ptr] <= item_b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (in_fire) begin
        wr_ptr <= wr_ptr + 2'(a_vld) + 2'(b_vld);
      end
      if (out_fire) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
    end
  end

  assign m_tvalid = (count != 3'd0);
  assign m_tdata  = {3'd0, q[rd_ptr].status, q[rd_ptr].point_flags, q[rd_ptr].word3,
                     q[rd_ptr].word2, q[rd_ptr].word1, q[rd_ptr].word0};
  assign m_tuser  = q[rd_ptr].kind;
  assign m_tlast  = q[rd_ptr].end_mark;

`include "result_packet_decoder_macros.svh"

  `RPD_ASSERT_ALWAYS(a_queue_bound, clk, rst, count <= 3'd4)
  `RPD_ASSERT_IMPL(a_idx_idle_in_header, clk, rst, pos < POS_HDR, pt_idx == 6'd0)
  `RPD_ASSERT_IMPL(a_hdr_ok_after_header, clk, rst, header_ok, pos >= POS_HDR)
  `RPD_ASSERT_NEXT(a_clear_after_last, clk, rst, in_fire && s_tlast,
    pos == '0 && crc == CRC_INIT && !header_ok && !flags_bad)

endmodule

`default_nettype wire
